@@ src/stt_pkg.sv @@
// Shared types, scan-mode codes, result kinds and character constants of the script tokeniser.
package stt_pkg;

  localparam int MAX_TOKEN_LEN = 1024;
  localparam int TOK_W         = 11;
  localparam int LINE_W        = 16;
  localparam int MAX_RES       = 5;
  localparam int NRES_W        = 3;

  localparam logic [TOK_W-1:0]  TOK_MAX  = TOK_W'(MAX_TOKEN_LEN);
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
  localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};

  // scan modes
  localparam logic [2:0] M_SKIP    = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_LINE    = 3'd2;
  localparam logic [2:0] M_BLOCK   = 3'd3;
  localparam logic [2:0] M_BSTAR   = 3'd4;
  localparam logic [2:0] M_QUOTED  = 3'd5;
  localparam logic [2:0] M_REGULAR = 3'd6;

  // result kinds
  localparam logic [2:0] K_CHAR       = 3'd0;
  localparam logic [2:0] K_END        = 3'd1;
  localparam logic [2:0] K_INCOMPLETE = 3'd2;
  localparam logic [2:0] K_TOOLONG    = 3'd3;
  localparam logic [2:0] K_EOS        = 3'd4;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        ch;
    logic [TOK_W-1:0]  len;
    logic              quoted;
    logic [LINE_W-1:0] line;
  } res_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [TOK_W-1:0]  cnt;
    logic [LINE_W-1:0] line;
  } scan_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  typedef struct packed {
    scan_t             st;
    logic [NRES_W-1:0] n;
    res_list_t         res;
  } work_t;

endpackage

@@ src/script_text_tokenizer_top.sv @@
// Top level of the script tokeniser: scanner state, byte scan and result register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | byte_value, last_byte, cross_line
//  out_    | output    | out_valid/out_stall| result_kind, char_value, token_len,
//          |           |                    | was_quoted, line_number, last_result
//
// A byte is scanned in the cycle it is taken; its words (up to five) sit in the
// result register from the next cycle and leave one per cycle while out_stall is low.
// A byte giving one word or none can follow with no gap unless out_stall holds its
// word; a byte giving more words holds the input off until its last word leaves.
// in_stall is high while the result register holds words other than a last word
// leaving this cycle. Reset: skipping whitespace, count 0, line 1, register empty.
module script_text_tokenizer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte_value,
  input  logic                         in_last_byte,
  input  logic                         in_cross_line,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_result_kind,
  output logic [7:0]                   out_char_value,
  output logic [stt_pkg::TOK_W-1:0]    out_token_len,
  output logic                         out_was_quoted,
  output logic [stt_pkg::LINE_W-1:0]   out_line_number,
  output logic                         out_last_result
);

  stt_pkg::scan_t              st_r;
  stt_pkg::scan_t              st_nxt;
  logic [stt_pkg::NRES_W-1:0]  n_res;
  stt_pkg::res_list_t          res;
  stt_pkg::res_t               cur;
  logic                        can_load;
  logic                        in_take;

  // byte accepted on the input side
  assign in_stall = !can_load;
  assign in_take  = in_valid && can_load;

  stt_step u_step (
    .byte_value (in_byte_value),
    .last_byte  (in_last_byte),
    .cross_line (in_cross_line),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .n_res      (n_res),
    .res        (res)
  );

  // scanner state moves only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= stt_pkg::M_SKIP;
      st_r.cnt  <= '0;
      st_r.line <= stt_pkg::LINE_ONE;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  stt_resbuf u_resbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take),
    .n_in      (n_res),
    .res_in    (res),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (cur),
    .out_last  (out_last_result)
  );

  assign out_result_kind = cur.kind;
  assign out_char_value  = cur.ch;
  assign out_token_len   = cur.len;
  assign out_was_quoted  = cur.quoted;
  assign out_line_number = cur.line;

endmodule

@@ src/stt_step.sv @@
// Combinational scan of one byte: next scanner state and the words it produces.
module stt_step (
  input  logic [7:0]                 byte_value,
  input  logic                       last_byte,
  input  logic                       cross_line,
  input  stt_pkg::scan_t             st,
  output stt_pkg::scan_t             st_nxt,
  output logic [stt_pkg::NRES_W-1:0] n_res,
  output stt_pkg::res_list_t         res
);

  function automatic stt_pkg::work_t emit(stt_pkg::work_t w, logic [2:0] kind,
                                          logic [7:0] ch, logic [stt_pkg::TOK_W-1:0] len);
    stt_pkg::work_t o;
    stt_pkg::res_t  r;
    o = w;
    r.kind   = kind;
    r.ch     = ch;
    r.len    = len;
    r.quoted = (w.st.mode == stt_pkg::M_QUOTED) &&
               (kind == stt_pkg::K_CHAR || kind == stt_pkg::K_END ||
                kind == stt_pkg::K_TOOLONG);
    r.line   = w.st.line;
    if (w.n < stt_pkg::NRES_W'(stt_pkg::MAX_RES)) begin
      o.res[w.n] = r;
      o.n        = w.n + stt_pkg::NRES_W'(1);
    end
    return o;
  endfunction

  function automatic stt_pkg::work_t line_inc(stt_pkg::work_t w);
    stt_pkg::work_t o;
    o = w;
    if (w.st.line != stt_pkg::LINE_SAT) begin
      o.st.line = w.st.line + stt_pkg::LINE_ONE;
    end
    return o;
  endfunction

  function automatic stt_pkg::work_t put_char(stt_pkg::work_t w, logic [7:0] b);
    stt_pkg::work_t o;
    o = w;
    if (w.st.cnt < stt_pkg::TOK_MAX) begin
      o = emit(o, stt_pkg::K_CHAR, b, '0);
      o.st.cnt = o.st.cnt + stt_pkg::TOK_W'(1);
      if (o.st.cnt == stt_pkg::TOK_MAX) begin
        o = emit(o, stt_pkg::K_TOOLONG, 8'd0, '0);
      end
    end
    return o;
  endfunction

  function automatic stt_pkg::work_t skip_byte(stt_pkg::work_t w, logic [7:0] b, logic cl);
    stt_pkg::work_t o;
    o = w;
    if (b <= stt_pkg::CH_SPACE) begin
      if (b == stt_pkg::CH_NL) begin
        if (!cl) begin
          o = emit(o, stt_pkg::K_INCOMPLETE, 8'd0, '0);
        end
        o = line_inc(o);
      end
      o.st.mode = stt_pkg::M_SKIP;
    end else if (b == stt_pkg::CH_SEMI || b == stt_pkg::CH_HASH) begin
      if (!cl) begin
        o = emit(o, stt_pkg::K_INCOMPLETE, 8'd0, '0);
      end
      o.st.mode = stt_pkg::M_LINE;
    end else if (b == stt_pkg::CH_SLASH) begin
      o.st.mode = stt_pkg::M_SLASH;
    end else if (b == stt_pkg::CH_QUOTE) begin
      o.st.mode = stt_pkg::M_QUOTED;
      o.st.cnt  = '0;
    end else begin
      o.st.mode = stt_pkg::M_REGULAR;
      o.st.cnt  = '0;
      o = put_char(o, b);
    end
    return o;
  endfunction

  function automatic stt_pkg::work_t regular_byte(stt_pkg::work_t w, logic [7:0] b,
                                                  logic cl);
    stt_pkg::work_t o;
    o = w;
    if (b <= stt_pkg::CH_SPACE || b == stt_pkg::CH_SEMI) begin
      o = emit(o, stt_pkg::K_END, 8'd0, o.st.cnt);
      o.st.mode = stt_pkg::M_SKIP;
      o.st.cnt  = '0;
      o = skip_byte(o, b, cl);
    end else begin
      o = put_char(o, b);
    end
    return o;
  endfunction

  stt_pkg::work_t w;

  always_comb begin
    w     = '0;
    w.st  = st;
    w.n   = '0;
    unique case (st.mode) inside
      stt_pkg::M_SLASH: begin
        if (byte_value == stt_pkg::CH_SLASH) begin
          if (!cross_line) begin
            w = emit(w, stt_pkg::K_INCOMPLETE, 8'd0, '0);
          end
          w.st.mode = stt_pkg::M_LINE;
        end else if (byte_value == stt_pkg::CH_STAR) begin
          if (!cross_line) begin
            w = emit(w, stt_pkg::K_INCOMPLETE, 8'd0, '0);
          end
          w.st.mode = stt_pkg::M_BLOCK;
        end else begin
          // lone slash opens a regular token
          w.st.mode = stt_pkg::M_REGULAR;
          w.st.cnt  = '0;
          w = put_char(w, stt_pkg::CH_SLASH);
          w = regular_byte(w, byte_value, cross_line);
        end
      end
      stt_pkg::M_LINE: begin
        if (byte_value == stt_pkg::CH_NL) begin
          w = line_inc(w);
          w.st.mode = stt_pkg::M_SKIP;
        end
      end
      stt_pkg::M_BLOCK, stt_pkg::M_BSTAR: begin
        if (st.mode == stt_pkg::M_BSTAR && byte_value == stt_pkg::CH_SLASH) begin
          w.st.mode = stt_pkg::M_SKIP;
        end else if (byte_value == stt_pkg::CH_STAR) begin
          w.st.mode = stt_pkg::M_BSTAR;
        end else begin
          if (byte_value == stt_pkg::CH_NL) begin
            w = line_inc(w);
          end
          w.st.mode = stt_pkg::M_BLOCK;
        end
      end
      stt_pkg::M_QUOTED: begin
        if (byte_value == stt_pkg::CH_QUOTE) begin
          w = emit(w, stt_pkg::K_END, 8'd0, w.st.cnt);
          w.st.mode = stt_pkg::M_SKIP;
          w.st.cnt  = '0;
        end else begin
          w = put_char(w, byte_value);
        end
      end
      stt_pkg::M_REGULAR: begin
        w = regular_byte(w, byte_value, cross_line);
      end
      default: begin
        w = skip_byte(w, byte_value, cross_line);
      end
    endcase

    if (last_byte) begin
      if (w.st.mode == stt_pkg::M_SLASH) begin
        w.st.mode = stt_pkg::M_REGULAR;
        w.st.cnt  = '0;
        w = put_char(w, stt_pkg::CH_SLASH);
      end
      if (w.st.mode == stt_pkg::M_REGULAR || w.st.mode == stt_pkg::M_QUOTED) begin
        w = emit(w, stt_pkg::K_END, 8'd0, w.st.cnt);
      end
      w.st.mode = stt_pkg::M_SKIP;
      w = emit(w, stt_pkg::K_EOS, 8'd0, '0);
      w.st.mode = stt_pkg::M_SKIP;
      w.st.cnt  = '0;
      w.st.line = stt_pkg::LINE_ONE;
    end
  end

  assign st_nxt = w.st;
  assign n_res  = w.n;
  assign res    = w.res;

endmodule

@@ src/stt_resbuf.sv @@
// Result register: holds the words of one byte and hands them out one per cycle while out_stall is low.
module stt_resbuf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [stt_pkg::NRES_W-1:0] n_in,
  input  stt_pkg::res_list_t         res_in,
  input  logic                       out_stall,
  output logic                       can_load,
  output logic                       out_valid,
  output stt_pkg::res_t              out_res,
  output logic                       out_last
);

  stt_pkg::res_list_t          res_r;
  logic [stt_pkg::NRES_W-1:0]  n_r, n_nxt;
  logic [stt_pkg::NRES_W-1:0]  idx_r, idx_nxt;
  logic                        take;
  logic                        drain_done;

  assign out_valid  = (n_r != '0);
  assign out_last   = (idx_r == n_r - stt_pkg::NRES_W'(1));
  assign out_res    = res_r[idx_r];
  assign take       = out_valid && !out_stall;
  assign drain_done = take && out_last;
  assign can_load   = !out_valid || drain_done;

  always_comb begin
    n_nxt   = n_r;
    idx_nxt = idx_r;
    if (load) begin
      n_nxt   = n_in;
      idx_nxt = '0;
    end else if (drain_done) begin
      n_nxt   = '0;
      idx_nxt = '0;
    end else if (take) begin
      idx_nxt = idx_r + stt_pkg::NRES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      idx_r <= '0;
    end else begin
      n_r   <= n_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule
